@@ hdl/smac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smac_pkg: shared definitions for the shadow memory access checker
// Field widths, item codes, default geometry and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package smac_pkg;

  localparam int ADDR_W   = 16;
  localparam int SIZE_W   = 16;
  localparam int SHADOW_W = 8;
  localparam int VIOL_W   = 2;

  localparam int ARENA_ADDR_BITS_DEF = 16;
  localparam int GRANULE_SHIFT_DEF   = 3;

  // Item modes.
  localparam logic MODE_SHADOW_WRITE = 1'b0;
  localparam logic MODE_CHECK        = 1'b1;

  // Violation codes.
  localparam logic [VIOL_W-1:0] VIOL_NONE   = 2'd0;
  localparam logic [VIOL_W-1:0] VIOL_WRAP   = 2'd1;
  localparam logic [VIOL_W-1:0] VIOL_POISON = 2'd2;

  typedef struct packed {
    logic clear;   // clearing pass writes one shadow entry
    logic accept;  // an item is taken this cycle
    logic prep;    // range setup and first shadow read
    logic walk;    // one granule examined
  } smac_cmd_t;

  typedef struct packed {
    logic clear_last; // clearing pass is at its last entry
    logic need_walk;  // the offered item is a nonempty check
    logic wrap;       // the held access runs past the arena top
    logic walk_done;  // the walk ends with the current granule
  } smac_status_t;

endpackage

@@ hdl/smac_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smac_ctrl: sequencing controller
// Runs the shadow clearing pass after reset, accepts items and steps a
// nonempty check through range setup and the granule walk.
// ----------------------------------------------------------------------------
module smac_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  smac_pkg::smac_status_t status,
  output smac_pkg::smac_cmd_t    cmd,
  output logic                  busy
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_WALK
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    case (state)
      ST_CLEAR: cmd.clear  = 1'b1;
      ST_IDLE:  cmd.accept = start;
      ST_PREP:  cmd.prep   = 1'b1;
      ST_WALK:  cmd.walk   = 1'b1;
      default:  cmd        = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      busy  <= 1'b1;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (status.clear_last) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
        ST_IDLE: begin
          // Shadow writes and empty checks finish in the datapath at once.
          if (start && status.need_walk) begin
            state <= ST_PREP;
            busy  <= 1'b1;
          end
        end
        ST_PREP: begin
          if (status.wrap) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end else begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (status.walk_done) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ hdl/smac_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smac_dp: checker datapath
// Holds the shadow RAM, the item registers, the range arithmetic, the
// granule walk pointer, the sticky report flag and the result registers.
// ----------------------------------------------------------------------------
module smac_dp #(
  parameter int ARENA_ADDR_BITS = smac_pkg::ARENA_ADDR_BITS_DEF,
  parameter int GRANULE_SHIFT   = smac_pkg::GRANULE_SHIFT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  smac_pkg::smac_cmd_t                  cmd,
  input  logic                                mode,
  input  logic [smac_pkg::ADDR_W-1:0]         address,
  input  logic [smac_pkg::SIZE_W-1:0]         access_size,
  input  logic signed [smac_pkg::SHADOW_W-1:0] shadow_value,
  input  logic                                is_write,
  output smac_pkg::smac_status_t               status,
  output logic                                done,
  output logic                                access_ok,
  output logic [smac_pkg::VIOL_W-1:0]         violation,
  output logic                                first_report,
  output logic                                was_write
);

  localparam int IDX_BITS = (ARENA_ADDR_BITS > GRANULE_SHIFT) ?
                            (ARENA_ADDR_BITS - GRANULE_SHIFT) : 0;
  localparam int IDX_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int DEPTH    = 1 << IDX_BITS;
  localparam int SUM_W    = (ARENA_ADDR_BITS + 1 > smac_pkg::SIZE_W + 1) ?
                            (ARENA_ADDR_BITS + 1) : (smac_pkg::SIZE_W + 1);
  localparam int OFF_EXT  = smac_pkg::SHADOW_W + 1;

  localparam logic [SUM_W-1:0] ARENA_SIZE = SUM_W'(1) << ARENA_ADDR_BITS;
  localparam logic [SUM_W-1:0] ARENA_MASK = ARENA_SIZE - SUM_W'(1);
  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(DEPTH - 1);

  logic [smac_pkg::SHADOW_W-1:0] shadow_mem [DEPTH];
  logic [smac_pkg::SHADOW_W-1:0] rd_data;

  logic [smac_pkg::ADDR_W-1:0] addr_q;
  logic [smac_pkg::SIZE_W-1:0] size_q;
  logic                        wr_q;
  logic [IDX_W-1:0]            last_g;
  logic [GRANULE_SHIFT-1:0]    last_off;
  logic [IDX_W-1:0]            cur_g;
  logic [IDX_W-1:0]            clr_idx;
  logic                        reported;

  logic [SUM_W-1:0]            sum;
  logic [SUM_W-1:0]            last;
  logic [IDX_W-1:0]            first_g;
  logic [IDX_W-1:0]            wr_g;
  logic [IDX_W-1:0]            rd_idx;
  logic [IDX_W-1:0]            we_idx;
  logic                        we;
  logic [smac_pkg::SHADOW_W-1:0] we_data;

  logic                        at_last;
  logic                        nonzero;
  logic                        poison_last;
  logic                        poisoned;

  logic                        emit;
  logic [smac_pkg::VIOL_W-1:0] viol;
  logic                        wr_echo;
  logic                        first;

  assign sum     = SUM_W'(addr_q) + SUM_W'(size_q);
  assign last    = sum - SUM_W'(1);
  assign first_g = IDX_W'(SUM_W'(addr_q) >> GRANULE_SHIFT);
  assign wr_g    = IDX_W'((SUM_W'(address) & ARENA_MASK) >> GRANULE_SHIFT);

  assign rd_idx  = cmd.prep ? first_g : (cur_g + IDX_W'(1));
  assign we      = cmd.clear || (cmd.accept && (mode == smac_pkg::MODE_SHADOW_WRITE));
  assign we_idx  = cmd.clear ? clr_idx : wr_g;
  assign we_data = cmd.clear ? '0 : $unsigned(shadow_value);

  always_ff @(posedge clk) begin
    if (we) begin
      shadow_mem[we_idx] <= we_data;
    end
    rd_data <= shadow_mem[rd_idx];
  end

  // In the last granule the end offset is compared with the shadow byte as
  // signed numbers, so a negative shadow byte always poisons.
  assign at_last     = (cur_g == last_g);
  assign nonzero     = (rd_data != '0);
  assign poison_last = nonzero &&
                       ($signed({{(OFF_EXT - GRANULE_SHIFT){1'b0}}, last_off}) >=
                        $signed({rd_data[smac_pkg::SHADOW_W-1], rd_data}));
  assign poisoned    = at_last ? poison_last : nonzero;

  always_comb begin
    status.clear_last = (clr_idx == LAST_IDX);
    status.need_walk  = (mode == smac_pkg::MODE_CHECK) && (access_size != '0);
    status.wrap       = (sum > ARENA_SIZE);
    status.walk_done  = at_last || nonzero;
  end

  always_comb begin
    emit    = 1'b0;
    viol    = smac_pkg::VIOL_NONE;
    wr_echo = 1'b0;
    if (cmd.accept) begin
      if (mode == smac_pkg::MODE_SHADOW_WRITE) begin
        emit = 1'b1;
      end else if (access_size == '0) begin
        emit    = 1'b1;
        wr_echo = is_write;
      end
    end
    if (cmd.prep && status.wrap) begin
      emit    = 1'b1;
      viol    = smac_pkg::VIOL_WRAP;
      wr_echo = wr_q;
    end
    if (cmd.walk && status.walk_done) begin
      emit    = 1'b1;
      viol    = poisoned ? smac_pkg::VIOL_POISON : smac_pkg::VIOL_NONE;
      wr_echo = wr_q;
    end
  end

  assign first = emit && (viol != smac_pkg::VIOL_NONE) && !reported;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx  <= '0;
      reported <= 1'b0;
      done     <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
      if (first) begin
        reported <= 1'b1;
      end
      done <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_q <= address;
      size_q <= access_size;
      wr_q   <= is_write;
    end
    if (cmd.prep) begin
      last_g   <= IDX_W'(last >> GRANULE_SHIFT);
      last_off <= last[GRANULE_SHIFT-1:0];
      cur_g    <= first_g;
    end else if (cmd.walk) begin
      cur_g <= cur_g + IDX_W'(1);
    end
    if (emit) begin
      access_ok    <= (viol == smac_pkg::VIOL_NONE);
      violation    <= viol;
      first_report <= first;
      was_write    <= wr_echo;
    end
  end

endmodule

@@ hdl/shadow_memory_access_checker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shadow_memory_access_checker_core: shadow memory access checker
// Keeps one signed shadow byte per granule of the arena and checks accesses
// against it, flagging wraparound and poisoned-granule violations.
// ----------------------------------------------------------------------------
// After reset the shadow RAM is cleared one entry per cycle, with busy high
// throughout the clearing pass. An item is taken when start is high and busy
// is low, and each item yields one result on done for a single cycle, which
// the receiver must take then. A shadow write or a zero-size check gives its
// result in the cycle after it is taken and leaves busy low, so items can
// follow every cycle. Any other check holds busy through range setup and
// then, unless it runs past the arena top, walks the shadow RAM one granule
// per cycle through its single read port, stopping at the first nonzero
// shadow byte or at the last granule; busy drops in the same cycle as its
// result appears on done.
module shadow_memory_access_checker_core #(
  parameter int ARENA_ADDR_BITS = smac_pkg::ARENA_ADDR_BITS_DEF,
  parameter int GRANULE_SHIFT   = smac_pkg::GRANULE_SHIFT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                mode,
  input  logic [smac_pkg::ADDR_W-1:0]         address,
  input  logic [smac_pkg::SIZE_W-1:0]         access_size,
  input  logic signed [smac_pkg::SHADOW_W-1:0] shadow_value,
  input  logic                                is_write,
  output logic                                done,
  output logic                                access_ok,
  output logic [smac_pkg::VIOL_W-1:0]         violation,
  output logic                                first_report,
  output logic                                was_write
);

  smac_pkg::smac_cmd_t    cmd;
  smac_pkg::smac_status_t status;

  smac_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  smac_dp #(
    .ARENA_ADDR_BITS (ARENA_ADDR_BITS),
    .GRANULE_SHIFT   (GRANULE_SHIFT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .mode         (mode),
    .address      (address),
    .access_size  (access_size),
    .shadow_value (shadow_value),
    .is_write     (is_write),
    .status       (status),
    .done         (done),
    .access_ok    (access_ok),
    .violation    (violation),
    .first_report (first_report),
    .was_write    (was_write)
  );

  // A result reports success exactly when it carries no violation.
  a_ok_matches_viol: assert property (@(posedge clk) disable iff (rst)
    done |-> (access_ok == (violation == smac_pkg::VIOL_NONE)))
    else $error("access_ok disagrees with violation code");

  // A first report always comes with a violation.
  a_first_has_viol: assert property (@(posedge clk) disable iff (rst)
    (done && first_report) |-> (violation != smac_pkg::VIOL_NONE))
    else $error("first_report without a violation");

  // A nonempty check needs the setup cycle, so no result follows it at once.
  a_check_not_immediate: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == smac_pkg::MODE_CHECK) && (access_size != '0))
    |=> !done)
    else $error("nonempty check finished without a setup cycle");

  // Nothing is accepted while the shadow RAM is being cleared.
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> (busy && !cmd.accept))
    else $error("item accepted during the clearing pass");

endmodule

@@ tb/sv/shadow_memory_access_checker_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shadow_memory_access_checker_core_tb: self-checking bench for the checker
// Marks shadow granules and checks accesses against them, first with a short
// directed list and then with random traffic aimed at a small hot window.
// Every beat taken by the block is judged by a shadow image kept here, and
// each done beat is compared field by field with the oldest verdict.
// ----------------------------------------------------------------------------
module shadow_memory_access_checker_core_tb;
  import smac_pkg::*;

  localparam int GRAN_SHIFT     = GRANULE_SHIFT_DEF;
  localparam int SHADOW_ENTRIES = 1 << (ARENA_ADDR_BITS_DEF - GRANULE_SHIFT_DEF);
  localparam int ARENA_BYTES    = 1 << ARENA_ADDR_BITS_DEF;
  localparam logic [ADDR_W-1:0] GRAN_MASK = ADDR_W'((1 << GRAN_SHIFT) - 1);
  localparam int RANDOM_ITEMS   = 1950;

  typedef struct {
    logic                       mode;
    logic [ADDR_W-1:0]          address;
    logic [SIZE_W-1:0]          access_size;
    logic signed [SHADOW_W-1:0] shadow_value;
    logic                       is_write;
    bit                         hold;  // wait until every verdict is back
  } access_cmd_t;

  typedef struct {
    logic              access_ok;
    logic [VIOL_W-1:0] violation;
    logic              first_report;
    logic              was_write;
  } verdict_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       mode = MODE_SHADOW_WRITE;
  logic [ADDR_W-1:0]          address = '0;
  logic [SIZE_W-1:0]          access_size = '0;
  logic signed [SHADOW_W-1:0] shadow_value = '0;
  logic                       is_write = 1'b0;
  logic                       done;
  logic                       access_ok;
  logic [VIOL_W-1:0]          violation;
  logic                       first_report;
  logic                       was_write;

  access_cmd_t                access_queue[$];
  verdict_t                   pending_verdicts[$];
  logic signed [SHADOW_W-1:0] shadow_img [SHADOW_ENTRIES];
  bit                         violation_seen;
  access_cmd_t                cur_cmd;
  int                         gap_left;
  int                         burst_left;
  int                         error_count;

  shadow_memory_access_checker_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .address      (address),
    .access_size  (access_size),
    .shadow_value (shadow_value),
    .is_write     (is_write),
    .done         (done),
    .access_ok    (access_ok),
    .violation    (violation),
    .first_report (first_report),
    .was_write    (was_write)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one accepted beat to the shadow image and returns its verdict.
  function automatic verdict_t judge_access(access_cmd_t c);
    verdict_t          v;
    logic [ADDR_W:0]   span_end;
    logic [ADDR_W-1:0] last_byte;
    int                g;
    int                g_last;
    logic [VIOL_W-1:0] code;
    code = VIOL_NONE;
    v.access_ok = 1'b1;
    v.violation = VIOL_NONE;
    v.first_report = 1'b0;
    v.was_write = 1'b0;
    if (c.mode == MODE_SHADOW_WRITE) begin
      shadow_img[c.address >> GRAN_SHIFT] = c.shadow_value;
      return v;
    end
    if (c.access_size != 0) begin
      span_end = {1'b0, c.address} + {1'b0, c.access_size};
      if (span_end > ARENA_BYTES) begin
        code = VIOL_WRAP;
      end else begin
        last_byte = ADDR_W'(span_end - 1);
        g_last = int'(last_byte >> GRAN_SHIFT);
        for (g = int'(c.address >> GRAN_SHIFT); g < g_last; g++) begin
          if (shadow_img[g] != 0) begin
            code = VIOL_POISON;
            break;
          end
        end
        // A partial granule only allows offsets below its shadow value.
        if (code == VIOL_NONE && shadow_img[g_last] != 0 &&
            int'(last_byte & GRAN_MASK) >= int'(shadow_img[g_last])) begin
          code = VIOL_POISON;
        end
      end
    end
    if (code != VIOL_NONE && !violation_seen) begin
      v.first_report = 1'b1;
      violation_seen = 1'b1;
    end
    v.access_ok = (code == VIOL_NONE);
    v.violation = code;
    v.was_write = c.is_write;
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_cmd(logic m, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] s,
                                    logic [SHADOW_W-1:0] sv, logic w, bit h);
    access_cmd_t c;
    c.mode = m;
    c.address = a;
    c.access_size = s;
    c.shadow_value = sv;
    c.is_write = w;
    c.hold = h;
    access_queue.push_back(c);
  endfunction

  // The fields a mode ignores still get random values.
  function automatic void queue_mark(logic [ADDR_W-1:0] a, logic [SHADOW_W-1:0] sv,
                                     bit h = 1'b0);
    queue_cmd(MODE_SHADOW_WRITE, a, SIZE_W'($urandom_range(0, 65535)), sv,
              1'($urandom_range(0, 1)), h);
  endfunction

  function automatic void queue_check(logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] s, logic w,
                                      bit h = 1'b0);
    queue_cmd(MODE_CHECK, a, s, SHADOW_W'($urandom_range(0, 255)), w, h);
  endfunction

  function automatic logic [SHADOW_W-1:0] pick_shadow_byte();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 8'd0;
    if (r < 75) return SHADOW_W'($urandom_range(1, 7));
    if (r < 90) return SHADOW_W'($urandom_range(128, 255));
    return SHADOW_W'($urandom_range(8, 127));
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Driver: one beat is offered at a time and held until busy is low.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pending_verdicts.push_back(judge_access(cur_cmd));
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (access_queue.size() != 0 &&
                     !(access_queue[0].hold && pending_verdicts.size() != 0)) begin
          cur_cmd = access_queue.pop_front();
          mode <= cur_cmd.mode;
          address <= cur_cmd.address;
          access_size <= cur_cmd.access_size;
          shadow_value <= cur_cmd.shadow_value;
          is_write <= cur_cmd.is_write;
          start <= 1'b1;
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: a done beat must be taken in its only cycle.
  always @(posedge clk) begin
    verdict_t v;
    if (!rst && done) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result beat with no verdict waiting, expected none, actual ok=%0d viol=%0d",
                 $time, access_ok, violation);
        error_count++;
      end else begin
        v = pending_verdicts.pop_front();
        check_field("access_ok", int'(v.access_ok), int'(access_ok));
        check_field("violation", int'(v.violation), int'(violation));
        check_field("first_report", int'(v.first_report), int'(first_report));
        check_field("was_write", int'(v.was_write), int'(was_write));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [ADDR_W-1:0] win_base;
    int                r;
    int                n;
    foreach (shadow_img[i]) shadow_img[i] = '0;
    violation_seen = 1'b0;
    gap_left = 0;
    burst_left = 0;
    error_count = 0;

    // Directed part: arena edges, partial and poisoned granules, walks.
    queue_check(16'h0000, 16'd1, 1'b0);
    queue_check(16'hFFFF, 16'd0, 1'b1);
    queue_check(16'hFFFF, 16'hFFFF, 1'b1);
    queue_check(16'hFFFF, 16'd1, 1'b0);
    queue_check(16'h0000, 16'hFFFF, 1'b1, 1'b1);
    queue_check(16'h0001, 16'hFFFF, 1'b0);
    queue_check(16'h0002, 16'hFFFF, 1'b1);
    queue_mark(16'h0010, 8'sd3, 1'b1);
    queue_check(16'h0010, 16'd3, 1'b0);
    queue_check(16'h0010, 16'd4, 1'b1);
    queue_check(16'h0008, 16'd11, 1'b0);
    queue_check(16'h0008, 16'd16, 1'b1);
    queue_mark(16'h0025, 8'h80);
    queue_check(16'h0020, 16'd1, 1'b0);
    queue_check(16'h0018, 16'd16, 1'b0);
    queue_check(16'h001E, 16'd20, 1'b1);
    queue_mark(16'h002F, 8'h7F);
    queue_check(16'h0028, 16'd8, 1'b0);
    queue_mark(16'hFFF8, 8'sd1);
    queue_check(16'hFFF8, 16'd1, 1'b1);
    queue_check(16'hFFF8, 16'd2, 1'b0);
    queue_check(16'hFFF8, 16'd9, 1'b1);
    queue_mark(16'h0017, 8'sd0);
    queue_check(16'h0010, 16'd8, 1'b0);
    queue_check(16'h0000, 16'h0030, 1'b1);

    // Random part: marks and checks mostly land in one hot window so that
    // checks see the granules just written; the rest is arena-wide noise.
    win_base = 16'h0000;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) win_base = ADDR_W'($urandom_range(0, 1023) << 6);
      r = $urandom_range(99);
      if (r < 35) begin
        queue_mark(ADDR_W'(win_base + $urandom_range(0, 63)), pick_shadow_byte(),
                   n % 250 == 0);
      end else if (r < 80) begin
        queue_check(ADDR_W'(win_base + $urandom_range(0, 63)),
                    SIZE_W'(($urandom_range(99) < 88) ? $urandom_range(0, 24) :
                                                       $urandom_range(25, 200)),
                    1'($urandom_range(0, 1)), n % 250 == 0);
      end else if (r < 88) begin
        r = $urandom_range(99);
        if (r < 50)
          queue_check(ADDR_W'($urandom_range(0, 65535)), SIZE_W'($urandom_range(0, 16)),
                      1'($urandom_range(0, 1)));
        else if (r < 95)
          queue_check(ADDR_W'(16'hFFFF - $urandom_range(0, 40)),
                      SIZE_W'($urandom_range(0, 48)), 1'($urandom_range(0, 1)));
        else
          queue_check(ADDR_W'($urandom_range(0, 65535)), SIZE_W'($urandom_range(0, 65535)),
                      1'($urandom_range(0, 1)));
      end else if (r < 89) begin
        queue_check(ADDR_W'($urandom_range(0, 1023)), SIZE_W'($urandom_range(4096, 32768)),
                    1'($urandom_range(0, 1)));
      end else begin
        queue_mark(ADDR_W'($urandom_range(0, 65535)), SHADOW_W'($urandom_range(0, 255)));
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (access_queue.size() != 0 || start || pending_verdicts.size() != 0)
      @(negedge clk);
    repeat (40) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $display("%0t: verdicts left over, expected 0, actual %0d", $time,
               pending_verdicts.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
